// ===== rtl/hex_escape_decoder_top_defines.svh =====
// Assertion macros shared by the hex escape decoder checker.
// Depends on nothing; included by the checker file.
`ifndef HEX_ESCAPE_DECODER_TOP_DEFINES_SVH
`define HEX_ESCAPE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define HED_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hex escape decoder: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define HED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hex escape decoder: next-cycle check failed");

`endif

// ===== rtl/hed_pkg.sv =====
// Shared types, character codes and the hex digit lookup for the decoder.
// No dependencies; used by the top level and the checker.
package hed_pkg;

    localparam int LEN_W   = 12;
    localparam int MAX_RES = 4;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd511;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } hed_in_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             out_last;
        logic [LEN_W-1:0] out_length;
        logic             truncated;
    } hed_out_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_digit_t;

    // Hex digit lookup; anything outside 0-9, A-F, a-f is not a digit.
    function automatic hex_digit_t hex_value(input logic [7:0] c);
        hex_digit_t r;
        r.ok  = 1'b0;
        r.val = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r.ok  = 1'b1;
            r.val = 4'(c - 8'h30);
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            r.ok  = 1'b1;
            r.val = 4'(c - 8'h37);
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            r.ok  = 1'b1;
            r.val = 4'(c - 8'h57);
        end
        return r;
    endfunction

endpackage

// ===== rtl/hex_escape_decoder_top.sv =====
// The first result word of an input word is shown in the cycle after the word is accepted.
// One input word per cycle while each yields at most one result word and the output is not stalled;
// an input word yielding more holds the input until its last result word leaves the single output port.
// Reset (asynchronous, active low) clears the decode state, empties the result buffer and sets
// max_len_reg to 511.
// Top level of the backslash-x hex escape decoder; depends on hed_pkg.
module hex_escape_decoder_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [hed_pkg::LEN_W-1:0]   cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  hed_pkg::hed_in_t            in_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output hed_pkg::hed_out_t           out_word
);

    localparam logic [1:0] PH_PLAIN  = 2'd0;
    localparam logic [1:0] PH_BSLASH = 2'd1;
    localparam logic [1:0] PH_X      = 2'd2;
    localparam logic [1:0] PH_DIGIT  = 2'd3;

    logic [hed_pkg::LEN_W-1:0]      max_len_reg;
    logic [1:0]                     phase_reg, phase_next;
    logic [7:0]                     held_reg, held_next;
    logic [hed_pkg::LEN_W-1:0]      count_reg, count_next;
    logic                           ovf_reg, ovf_next;

    hed_pkg::hed_out_t              res_reg [hed_pkg::MAX_RES];
    hed_pkg::hed_out_t              res_next [hed_pkg::MAX_RES];
    logic [hed_pkg::RES_IDX_W-1:0]  rd_reg;
    logic [hed_pkg::RES_CNT_W-1:0]  rem_reg;
    logic [hed_pkg::RES_CNT_W-1:0]  load_n;

    logic [7:0]                     cand [hed_pkg::MAX_RES];
    logic [hed_pkg::RES_CNT_W-1:0]  cand_n;
    logic [hed_pkg::RES_CNT_W-1:0]  kept;
    logic [hed_pkg::LEN_W-1:0]      room;
    hed_pkg::hex_digit_t            hi_dig, lo_dig;
    logic [7:0]                     pair_val;
    logic                           in_fire, out_fire;

    // Handshakes: take a new word once the buffer is empty or its last word leaves now.
    assign out_valid = (rem_reg != '0);
    assign out_fire  = out_valid && !out_stall;
    assign in_stall  = !((rem_reg == '0) ||
                         ((rem_reg == hed_pkg::RES_CNT_W'(1)) && out_fire));
    assign in_fire   = in_valid && !in_stall;
    assign out_word  = res_reg[rd_reg];

    // Escape decode: candidate bytes this input word would emit, and the next phase.
    always_comb
    begin
        hi_dig     = hed_pkg::hex_value(held_reg);
        lo_dig     = hed_pkg::hex_value(in_word.in_byte);
        pair_val   = {hi_dig.val, lo_dig.val};
        phase_next = PH_PLAIN;
        held_next  = held_reg;
        cand_n     = '0;
        for (int k = 0; k < hed_pkg::MAX_RES; k++)
        begin
            cand[k] = 8'd0;
        end

        case (phase_reg)
            PH_PLAIN:
            begin
                if (in_word.in_byte == hed_pkg::CH_BSLASH)
                begin
                    phase_next = PH_BSLASH;
                end
                else
                begin
                    cand[0] = in_word.in_byte;
                    cand_n  = hed_pkg::RES_CNT_W'(1);
                end
            end
            PH_BSLASH:
            begin
                if (in_word.in_byte == hed_pkg::CH_X)
                begin
                    phase_next = PH_X;
                end
                else
                begin
                    cand[0] = hed_pkg::CH_BSLASH;
                    cand[1] = in_word.in_byte;
                    cand_n  = hed_pkg::RES_CNT_W'(2);
                end
            end
            PH_X:
            begin
                if (lo_dig.ok)
                begin
                    held_next  = in_word.in_byte;
                    phase_next = PH_DIGIT;
                end
                else
                begin
                    cand[0] = hed_pkg::CH_BSLASH;
                    cand[1] = hed_pkg::CH_X;
                    cand[2] = in_word.in_byte;
                    cand_n  = hed_pkg::RES_CNT_W'(3);
                end
            end
            default:
            begin
                if (hi_dig.ok && lo_dig.ok && (pair_val != 8'd0))
                begin
                    cand[0] = pair_val;
                    cand_n  = hed_pkg::RES_CNT_W'(1);
                end
                else
                begin
                    // Failed escape goes out literally; the second byte is plain text.
                    cand[0] = hed_pkg::CH_BSLASH;
                    cand[1] = hed_pkg::CH_X;
                    cand[2] = held_reg;
                    if (in_word.in_byte == hed_pkg::CH_BSLASH)
                    begin
                        phase_next = PH_BSLASH;
                        cand_n     = hed_pkg::RES_CNT_W'(3);
                    end
                    else
                    begin
                        cand[3] = in_word.in_byte;
                        cand_n  = hed_pkg::RES_CNT_W'(4);
                    end
                end
            end
        endcase

        // A value that ends on a single held digit flushes the escape literally.
        if (in_word.in_last && (phase_next == PH_DIGIT))
        begin
            cand[0] = hed_pkg::CH_BSLASH;
            cand[1] = hed_pkg::CH_X;
            cand[2] = in_word.in_byte;
            cand_n  = hed_pkg::RES_CNT_W'(3);
        end
    end

    // Length limit: only a prefix of the candidates fits in the remaining room.
    always_comb
    begin
        room = max_len_reg - count_reg;
        if (count_reg >= max_len_reg)
        begin
            kept = '0;
        end
        else if (room < hed_pkg::LEN_W'(cand_n))
        begin
            kept = hed_pkg::RES_CNT_W'(room);
        end
        else
        begin
            kept = cand_n;
        end
        ovf_next   = ovf_reg || (kept != cand_n);
        count_next = count_reg + hed_pkg::LEN_W'(kept);
    end

    // Result words for the buffer, with the end marker when nothing is kept at the end.
    always_comb
    begin
        for (int k = 0; k < hed_pkg::MAX_RES; k++)
        begin
            res_next[k].out_byte   = cand[k];
            res_next[k].byte_valid = 1'b1;
            res_next[k].out_last   = in_word.in_last &&
                                     (kept == hed_pkg::RES_CNT_W'(k + 1));
            res_next[k].out_length = count_reg + hed_pkg::LEN_W'(k + 1);
            res_next[k].truncated  = ovf_next;
        end
        load_n = kept;
        if (in_word.in_last && (kept == '0))
        begin
            res_next[0].out_byte   = 8'd0;
            res_next[0].byte_valid = 1'b0;
            res_next[0].out_last   = 1'b1;
            res_next[0].out_length = count_reg;
            load_n                 = hed_pkg::RES_CNT_W'(1);
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= hed_pkg::MAX_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // Decode state; an end-of-value word returns it to plain text.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PLAIN;
            held_reg  <= 8'd0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            if (in_word.in_last)
            begin
                phase_reg <= PH_PLAIN;
                held_reg  <= 8'd0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // Result buffer control: load on accept, drain one word per output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            rem_reg <= '0;
        end
        else if (in_fire)
        begin
            rd_reg  <= '0;
            rem_reg <= load_n;
        end
        else if (out_fire)
        begin
            rd_reg  <= rd_reg + hed_pkg::RES_IDX_W'(1);
            rem_reg <= rem_reg - hed_pkg::RES_CNT_W'(1);
        end
    end

    // Result buffer payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int k = 0; k < hed_pkg::MAX_RES; k++)
            begin
                res_reg[k] <= res_next[k];
            end
        end
    end

endmodule

// ===== rtl/hed_checker.sv =====
// Port-level checks for the hex escape decoder, bound to the top level.
// Depends on hed_pkg and hex_escape_decoder_top_defines.svh.
`include "hex_escape_decoder_top_defines.svh"

module hed_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  hed_pkg::hed_out_t           out_word
);

    logic                        out_mid;
    logic                        mid_trunc;
    logic [hed_pkg::LEN_W-1:0]   out_len;
    logic [hed_pkg::LEN_W-1:0]   len_base;

    // An output word accepted that does not close the value.
    assign out_mid   = out_valid && !out_stall && !out_word.out_last;
    assign mid_trunc = out_mid && out_word.truncated;

    // Length before this word: one less for a byte, the same for the end marker.
    assign out_len  = out_word.out_length;
    assign len_base = out_len - hed_pkg::LEN_W'(out_word.byte_valid);

    // A stalled output word stays put.
    `HED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))

    // A word without a byte is only ever the end marker.
    `HED_ASSERT_NOW(a_marker_last, clk, rst_n, out_valid && !out_word.byte_valid, out_word.out_last)

    // Within a value the length grows by one per byte, and the marker repeats it.
    `HED_ASSERT_NEXT(a_len_step, clk, rst_n, out_mid, !out_valid || (len_base == $past(out_len)))

    // Once set within a value, the truncated flag stays set.
    `HED_ASSERT_NEXT(a_trunc_sticky, clk, rst_n, mid_trunc, !out_valid || out_word.truncated)

endmodule

bind hex_escape_decoder_top hed_checker u_hed_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for hex_escape_decoder_top: directed and random escaped values,
// random idling on both sides, and a scoreboard that predicts every result word.
// Depends on hed_pkg and the hex_escape_decoder_top RTL.
module testbench;
    import hed_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 50;

    typedef enum logic [1:0] {ESC_PLAIN, ESC_BSLASH, ESC_X, ESC_DIGIT} esc_phase_t;
    typedef logic [7:0] byte_q_t[$];

    // Tracks the decode state and holds the result words still owed by the block.
    class escape_decode_tracker;
        logic [LEN_W-1:0] limit_len;
        esc_phase_t       phase;
        logic [7:0]       held_char;
        logic [LEN_W-1:0] kept_count;
        logic             dropped;
        hed_out_t         expected_words[$];
        hed_out_t         step_words[$];
        int               errors;

        function new();
            limit_len  = MAX_LEN_RESET;
            phase      = ESC_PLAIN;
            held_char  = '0;
            kept_count = '0;
            dropped    = 1'b0;
            errors     = 0;
        endfunction

        // Value of a hex digit character, or -1 for anything else.
        function int digit_value(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return int'(c - "0");
            if (c >= "A" && c <= "F")
                return int'(c - "A") + 10;
            if (c >= "a" && c <= "f")
                return int'(c - "a") + 10;
            return -1;
        endfunction

        // Keep one decoded byte unless the length limit has been reached.
        function void put_byte(logic [7:0] b);
            hed_out_t w;
            if (kept_count < limit_len && step_words.size() < MAX_RES)
            begin
                kept_count   = kept_count + 1'b1;
                w            = '0;
                w.out_byte   = b;
                w.byte_valid = 1'b1;
                w.out_length = kept_count;
                step_words.push_back(w);
            end
            else
            begin
                dropped = 1'b1;
            end
        endfunction

        function void plain_byte(logic [7:0] b);
            if (b == CH_BSLASH)
                phase = ESC_BSLASH;
            else
                put_byte(b);
        endfunction

        // Note one accepted input word and queue the result words it causes.
        function void take_byte(hed_in_t item);
            int       hi;
            int       lo;
            hed_out_t w;
            step_words.delete();
            case (phase)
                ESC_PLAIN:
                begin
                    plain_byte(item.in_byte);
                end
                ESC_BSLASH:
                begin
                    phase = ESC_PLAIN;
                    if (item.in_byte == CH_X)
                    begin
                        phase = ESC_X;
                    end
                    else
                    begin
                        put_byte(CH_BSLASH);
                        put_byte(item.in_byte);
                    end
                end
                ESC_X:
                begin
                    phase = ESC_PLAIN;
                    if (digit_value(item.in_byte) >= 0)
                    begin
                        held_char = item.in_byte;
                        phase     = ESC_DIGIT;
                    end
                    else
                    begin
                        put_byte(CH_BSLASH);
                        put_byte(CH_X);
                        put_byte(item.in_byte);
                    end
                end
                default:
                begin
                    hi    = digit_value(held_char);
                    lo    = digit_value(item.in_byte);
                    phase = ESC_PLAIN;
                    if (hi >= 0 && lo >= 0 && (hi * 16 + lo) != 0)
                    begin
                        put_byte(8'(hi * 16 + lo));
                    end
                    else
                    begin
                        // Failed escape goes out literally; the second digit is plain text.
                        put_byte(CH_BSLASH);
                        put_byte(CH_X);
                        put_byte(held_char);
                        plain_byte(item.in_byte);
                    end
                end
            endcase

            // The end of a value flushes a held digit and always closes with a last word.
            if (item.in_last)
            begin
                if (phase == ESC_DIGIT)
                begin
                    put_byte(CH_BSLASH);
                    put_byte(CH_X);
                    put_byte(held_char);
                end
                if (step_words.size() == 0)
                begin
                    w            = '0;
                    w.out_length = kept_count;
                    step_words.push_back(w);
                end
                w          = step_words.pop_back();
                w.out_last = 1'b1;
                step_words.push_back(w);
            end

            foreach (step_words[i])
            begin
                w           = step_words[i];
                w.truncated = dropped;
                expected_words.push_back(w);
            end

            if (item.in_last)
            begin
                phase      = ESC_PLAIN;
                held_char  = '0;
                kept_count = '0;
                dropped    = 1'b0;
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, logic [LEN_W-1:0] got_v, logic [LEN_W-1:0] want_v);
            if (got_v !== want_v)
                report_mismatch($sformatf("%s got %0h, expected %0h", name, got_v, want_v));
        endtask

        // Compare one accepted result word with the oldest expected word.
        task check_word(hed_out_t got);
            hed_out_t want;
            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word byte %02h length %0d",
                                          got.out_byte, got.out_length));
                return;
            end
            want = expected_words.pop_front();
            compare_field("out_byte", LEN_W'(got.out_byte), LEN_W'(want.out_byte));
            compare_field("byte_valid", LEN_W'(got.byte_valid), LEN_W'(want.byte_valid));
            compare_field("out_last", LEN_W'(got.out_last), LEN_W'(want.out_last));
            compare_field("out_length", got.out_length, want.out_length);
            compare_field("truncated", LEN_W'(got.truncated), LEN_W'(want.truncated));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    hed_in_t          in_word = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    hed_out_t         out_word;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycles = 0;
    int items_sent = 0;

    escape_decode_tracker tracker = new();

    hex_escape_decoder_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver stalls at random.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Check every result word accepted at this edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            tracker.check_word(out_word);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Random hex digit character, either case for letters.
    function automatic logic [7:0] hex_char();
        logic [7:0] d;
        d = 8'($urandom_range(15));
        if (d < 10)
            return 8'("0" + d);
        return 8'(($urandom_range(1) ? "a" : "A") + d - 10);
    endfunction

    // One random value: mostly well-formed escapes with random digits, some noise,
    // some broken escapes, and now and then an escape left open at the end.
    function automatic byte_q_t random_value();
        byte_q_t v;
        int      tokens;
        int      kind;
        tokens = $urandom_range(1, 5);
        for (int t = 0; t < tokens; t++)
        begin
            kind = $urandom_range(99);
            if (kind < 55)
            begin
                v.push_back(CH_BSLASH);
                v.push_back(CH_X);
                if ($urandom_range(19) == 0)
                begin
                    v.push_back("0");
                    v.push_back("0");
                end
                else
                begin
                    v.push_back(hex_char());
                    v.push_back(hex_char());
                end
            end
            else if (kind < 80)
            begin
                v.push_back(8'($urandom_range(255)));
            end
            else if (kind < 88)
            begin
                v.push_back(CH_BSLASH);
                v.push_back(8'($urandom_range(255)));
            end
            else if (kind < 94)
            begin
                v.push_back(CH_BSLASH);
                v.push_back(CH_X);
                v.push_back(8'($urandom_range(255)));
            end
            else
            begin
                v.push_back(CH_BSLASH);
                v.push_back(CH_X);
                v.push_back(hex_char());
                v.push_back(8'($urandom_range(255)));
            end
        end
        case ($urandom_range(9))
            0: v.push_back(CH_BSLASH);
            1:
            begin
                v.push_back(CH_BSLASH);
                v.push_back(CH_X);
            end
            2:
            begin
                v.push_back(CH_BSLASH);
                v.push_back(CH_X);
                v.push_back(hex_char());
            end
            default: ;
        endcase
        return v;
    endfunction

    // Present one word, with an optional random gap before it, and wait for acceptance.
    task send_byte(logic [7:0] b, logic last);
        hed_in_t item;
        item.in_byte = b;
        item.in_last = last;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_word  <= item;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        tracker.take_byte(item);
        items_sent++;
    endtask

    task send_value(byte_q_t v);
        foreach (v[i])
            send_byte(v[i], i == v.size() - 1);
    endtask

    task send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // Let every owed word drain, then wait out the settle time for words that cause none.
    task wait_idle();
        in_valid <= 1'b0;
        while (tracker.expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_limit(logic [LEN_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.limit_len = value;
    endtask

    // Main sequence: reset, directed values, then random phases.
    initial
    begin
        logic [LEN_W-1:0] limits [PHASES];
        byte_q_t          vals;
        int               target;

        limits[0] = 12'd4095;
        limits[1] = 12'd1;
        limits[2] = 12'd3;
        limits[3] = 12'd2;
        limits[4] = LEN_W'($urandom_range(4, 24));
        limits[5] = 12'd4095;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 30;
        recv_idle_pct = 82;

        // Directed values at the reset length limit.
        send_text("\\xA5z");        // decoded byte then plain text
        send_text("\\x00");         // zero value passes through literally
        send_text("\\xg");          // bad first digit
        send_text("\\x4");          // single digit left at the end
        send_text("\\");            // lone backslash at the end: bare end marker
        send_text("\\x");           // backslash-x at the end is dropped
        send_text("\\q");           // backslash without x
        vals = '{CH_BSLASH, CH_X, "1", 8'hFF};
        send_value(vals);           // high byte is never a digit
        vals = '{8'h00};
        send_value(vals);
        wait_idle();

        // Random phases, each writing its own length limit; pairs of phases share an idling pattern.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p / 2)
                0:
                begin
                    send_idle_pct = 30;
                    recv_idle_pct = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_idle_pct = 30;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_limit(limits[p]);
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
                send_value(random_value());
            wait_idle();
        end

        if (tracker.errors == 0 && tracker.expected_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/hed_pkg.sv
rtl/hex_escape_decoder_top.sv
rtl/hed_checker.sv
bench/testbench.sv
